@@ hw/rtl/eiph_pkg.sv @@
// Shared constants and types for the Ethernet IPv4/IPv6 header parser.
package eiph_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned POS_W       = 16;
    localparam int unsigned ADDR_HALF_W = 64;
    localparam int unsigned PORT_W      = 16;

    // Packed result layout, lowest bit first
    localparam int unsigned OUT_DATA_W  = 208;
    localparam int unsigned OUT_USER_W  = 3;

    localparam logic [POS_W-1:0] POS_MAX       = 16'hFFFF;
    localparam logic [POS_W-1:0] ETYPE_POS_HI  = 16'd12;
    localparam logic [POS_W-1:0] ETYPE_POS_LO  = 16'd13;
    localparam logic [POS_W-1:0] ETH_HDR_LEN   = 16'd14;
    localparam logic [POS_W-1:0] V4_FRAG_HI    = 16'd20;
    localparam logic [POS_W-1:0] V4_FRAG_LO    = 16'd21;
    localparam logic [POS_W-1:0] V4_PROTO_POS  = 16'd23;
    localparam logic [POS_W-1:0] V4_SRC_FIRST  = 16'd26;
    localparam logic [POS_W-1:0] V4_SRC_LAST   = 16'd29;
    localparam logic [POS_W-1:0] V6_NH_POS     = 16'd20;
    localparam logic [POS_W-1:0] V6_SRC_FIRST  = 16'd22;
    localparam logic [POS_W-1:0] V6_SRC_MID    = 16'd29;
    localparam logic [POS_W-1:0] V6_SRC_LOW    = 16'd30;
    localparam logic [POS_W-1:0] V6_SRC_LAST   = 16'd37;
    localparam logic [POS_W-1:0] V6_TRANSPORT  = 16'd54;
    localparam logic [POS_W-1:0] V4_MIN_LEN    = 16'd34;
    localparam logic [POS_W-1:0] TRANSPORT_SPAN = 16'd14;
    localparam logic [POS_W-1:0] TCP_HDR_LEN   = 16'd20;
    localparam logic [POS_W-1:0] UDP_HDR_LEN   = 16'd8;

    localparam logic [15:0] TYPE_V4      = 16'h0800;
    localparam logic [15:0] TYPE_V6      = 16'h86DD;
    localparam logic [15:0] RESERVED_BIT = 16'h8000;
    localparam logic [15:0] FRAG_MASK    = 16'h3FFF;
    localparam logic [3:0]  MIN_IHL      = 4'd5;

    localparam logic [7:0] PROTO_TCP   = 8'd6;
    localparam logic [7:0] PROTO_UDP   = 8'd17;
    localparam logic [7:0] PROTO_FRAG6 = 8'd44;

    // Byte offsets inside the transport header
    localparam logic [3:0] TP_SRC_HI  = 4'd0;
    localparam logic [3:0] TP_SRC_LO  = 4'd1;
    localparam logic [3:0] TP_DST_HI  = 4'd2;
    localparam logic [3:0] TP_DST_LO  = 4'd3;
    localparam logic [3:0] TCP_OFF_IDX  = 4'd12;
    localparam logic [3:0] TCP_FLAG_IDX = 4'd13;

    typedef enum logic [1:0] {
        FAM_NONE = 2'd0,
        FAM_V4   = 2'd1,
        FAM_V6   = 2'd2
    } t_family;

endpackage

@@ hw/rtl/ethernet_ip_header_parser.sv @@
// Ethernet IPv4/IPv6 header parser: one frame byte per item, one summary per frame.
//
// Frame bytes enter one per cycle on the slave stream, starting at the
// destination MAC, with tlast on the final byte. The block takes one byte
// every cycle at full rate; only a final byte waits, and only while the
// previous summary still sits unread in the result register. A registered
// input stage feeds the header capture logic; when the stored last byte
// advances, the frame summary is loaded onto the master stream. Rejected
// frames (wrong EtherType, too short, IHL below 5, IPv4 reserved bit set)
// give a summary with every field zero. Extension headers of IPv6 are not
// walked: the transport header is taken at frame offset 54.
module ethernet_ip_header_parser
    import eiph_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [BYTE_W-1:0]     s_axis_tdata,   // data_byte[7:0]
    input  logic                  s_axis_tlast,   // last_byte
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // protocol[7:0], fragmented[8], dst_port[24:9], src_port[40:25],
    // tcp_flags[48:41], tcp_offset_byte[56:49], src_addr_high[120:57],
    // src_addr_low[184:121], frame_length[200:185], zero fill [207:201]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // accepted[0], family[2:1]
    output logic [OUT_USER_W-1:0] m_axis_tuser
);

    // Input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;

    // Per-frame header state
    logic [POS_W-1:0]       r_pos,       n_pos;
    logic [15:0]            r_etype,     n_etype;
    logic [3:0]             r_ihl,       n_ihl;
    logic [15:0]            r_frag,      n_frag;
    logic [7:0]             r_proto,     n_proto;
    logic [ADDR_HALF_W-1:0] r_addr_hi,   n_addr_hi;
    logic [ADDR_HALF_W-1:0] r_addr_lo,   n_addr_lo;
    logic [PORT_W-1:0]      r_dst_port,  n_dst_port;
    logic [PORT_W-1:0]      r_src_port,  n_src_port;
    logic [7:0]             r_flags,     n_flags;
    logic [7:0]             r_offset,    n_offset;

    // Result register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data,  n_out_data;
    logic [OUT_USER_W-1:0] r_out_user,  n_out_user;

    logic w_out_free;
    logic w_adv;

    // Advance the stored item unless it closes a frame and the result is still held
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_adv         = r_in_valid && (!r_in_last || w_out_free);
    assign s_axis_tready = !r_in_valid || w_adv;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // Capture header fields from the stored byte
    always_comb begin
        logic [POS_W-1:0] pos;
        logic [7:0]       b;
        logic [POS_W-1:0] tp_v4;
        logic [POS_W-1:0] tp_rel;
        logic             tp_hit;
        logic [2:0]       slot;
        logic [POS_W-1:0] rel_pos;

        pos = r_pos;
        b   = r_in_byte;

        n_pos      = (r_pos == POS_MAX) ? r_pos : r_pos + 16'd1;
        n_etype    = r_etype;
        n_ihl      = r_ihl;
        n_frag     = r_frag;
        n_proto    = r_proto;
        n_addr_hi  = r_addr_hi;
        n_addr_lo  = r_addr_lo;
        n_dst_port = r_dst_port;
        n_src_port = r_src_port;
        n_flags    = r_flags;
        n_offset   = r_offset;

        tp_v4   = ETH_HDR_LEN + {10'd0, r_ihl, 2'b00};
        tp_rel  = '0;
        tp_hit  = 1'b0;
        slot    = '0;
        rel_pos = '0;

        if (pos == ETYPE_POS_HI) begin
            n_etype[15:8] = b;
        end else if (pos == ETYPE_POS_LO) begin
            n_etype[7:0] = b;
        end

        if (r_etype == TYPE_V4 && pos >= ETH_HDR_LEN) begin
            if (pos == ETH_HDR_LEN) begin
                n_ihl = b[3:0];
            end else if (pos == V4_FRAG_HI) begin
                n_frag[15:8] = b;
            end else if (pos == V4_FRAG_LO) begin
                n_frag[7:0] = b;
            end else if (pos == V4_PROTO_POS) begin
                n_proto = b;
            end else if (pos >= V4_SRC_FIRST && pos <= V4_SRC_LAST) begin
                rel_pos = pos - V4_SRC_FIRST;
                slot    = 3'd7 - rel_pos[2:0];
                n_addr_hi[{slot, 3'b000} +: 8] = b;
            end
            if (pos > ETH_HDR_LEN && r_ihl >= MIN_IHL &&
                pos >= tp_v4 && pos < tp_v4 + TRANSPORT_SPAN) begin
                tp_hit = 1'b1;
                tp_rel = pos - tp_v4;
            end
        end else if (r_etype == TYPE_V6 && pos >= ETH_HDR_LEN) begin
            if (pos == V6_NH_POS) begin
                n_proto = b;
            end else if (pos >= V6_SRC_FIRST && pos <= V6_SRC_MID) begin
                rel_pos = pos - V6_SRC_FIRST;
                slot    = 3'd7 - rel_pos[2:0];
                n_addr_hi[{slot, 3'b000} +: 8] = b;
            end else if (pos >= V6_SRC_LOW && pos <= V6_SRC_LAST) begin
                rel_pos = pos - V6_SRC_LOW;
                slot    = 3'd7 - rel_pos[2:0];
                n_addr_lo[{slot, 3'b000} +: 8] = b;
            end else if (pos >= V6_TRANSPORT && pos < V6_TRANSPORT + TRANSPORT_SPAN) begin
                tp_hit = 1'b1;
                tp_rel = pos - V6_TRANSPORT;
            end
        end

        // Grab ports and TCP bytes from the transport header
        if (tp_hit) begin
            case (tp_rel[3:0])
                TP_SRC_HI:    n_src_port[15:8] = b;
                TP_SRC_LO:    n_src_port[7:0]  = b;
                TP_DST_HI:    n_dst_port[15:8] = b;
                TP_DST_LO:    n_dst_port[7:0]  = b;
                TCP_OFF_IDX:  n_offset         = b;
                TCP_FLAG_IDX: n_flags          = b;
                default:      ;
            endcase
        end
    end

    // Build the frame summary from the updated header state
    always_comb begin
        logic [POS_W-1:0]       len;
        logic [POS_W-1:0]       tp_v4;
        logic [POS_W-1:0]       tp_start;
        logic                   is_v4;
        logic                   is_v6;
        logic                   ok;
        logic                   frag;
        logic                   tcp_ok;
        logic                   udp_ok;
        logic [PORT_W-1:0]      dst;
        logic [PORT_W-1:0]      src;
        logic [7:0]             flg;
        logic [7:0]             off;
        logic [ADDR_HALF_W-1:0] a_hi;
        logic [ADDR_HALF_W-1:0] a_lo;
        t_family                fam;

        len      = n_pos;
        tp_v4    = ETH_HDR_LEN + {10'd0, n_ihl, 2'b00};
        is_v4    = (n_etype == TYPE_V4);
        is_v6    = (n_etype == TYPE_V6);
        tp_start = is_v4 ? tp_v4 : V6_TRANSPORT;

        if (is_v4) begin
            ok = len >= V4_MIN_LEN && n_ihl >= MIN_IHL && len >= tp_v4 &&
                 (n_frag & RESERVED_BIT) == 16'd0;
        end else if (is_v6) begin
            ok = len >= V6_TRANSPORT;
        end else begin
            ok = 1'b0;
        end

        frag   = is_v4 ? ((n_frag & FRAG_MASK) != 16'd0) : (n_proto == PROTO_FRAG6);
        tcp_ok = ok && !frag && n_proto == PROTO_TCP && len >= tp_start + TCP_HDR_LEN;
        udp_ok = ok && !frag && n_proto == PROTO_UDP && len >= tp_start + UDP_HDR_LEN;

        dst  = (tcp_ok || udp_ok) ? n_dst_port : '0;
        src  = (tcp_ok || udp_ok) ? n_src_port : '0;
        flg  = tcp_ok ? n_flags  : '0;
        off  = tcp_ok ? n_offset : '0;
        a_hi = !ok ? '0 : (is_v4 ? {n_addr_hi[63:32], 32'd0} : n_addr_hi);
        a_lo = (ok && is_v6) ? n_addr_lo : '0;
        fam  = !ok ? FAM_NONE : (is_v4 ? FAM_V4 : FAM_V6);

        n_out_data = {7'd0, (ok ? len : 16'd0), a_lo, a_hi, off, flg, src, dst,
                      (ok && frag), (ok ? n_proto : 8'd0)};
        n_out_user = {fam, ok};
    end

    // Hold the incoming byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // Advance header state; clear it after the last byte of a frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_adv && r_in_last)) begin
            r_pos      <= '0;
            r_etype    <= '0;
            r_ihl      <= '0;
            r_frag     <= '0;
            r_proto    <= '0;
            r_addr_hi  <= '0;
            r_addr_lo  <= '0;
            r_dst_port <= '0;
            r_src_port <= '0;
            r_flags    <= '0;
            r_offset   <= '0;
        end else if (w_adv) begin
            r_pos      <= n_pos;
            r_etype    <= n_etype;
            r_ihl      <= n_ihl;
            r_frag     <= n_frag;
            r_proto    <= n_proto;
            r_addr_hi  <= n_addr_hi;
            r_addr_lo  <= n_addr_lo;
            r_dst_port <= n_dst_port;
            r_src_port <= n_src_port;
            r_flags    <= n_flags;
            r_offset   <= n_offset;
        end
    end

    // Load the result register at end of frame, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_adv && r_in_last) begin
            r_out_data <= n_out_data;
            r_out_user <= n_out_user;
        end
    end

    // A rejected frame carries an all-zero summary
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_user[0]) |-> (r_out_data == '0 && r_out_user == '0))
        else $error("rejected frame summary not zero");

    // Accepted frames always name a family and meet the minimum length
    a_accept_family: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_user[0]) |->
        (r_out_user[2:1] != FAM_NONE && r_out_data[200:185] >= V4_MIN_LEN))
        else $error("accepted frame without family or too short");

    // Fragments never report transport fields
    a_frag_no_ports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[8]) |-> (r_out_data[56:9] == '0))
        else $error("fragment reports transport fields");

    // Header state restarts after each frame
    a_state_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_last) |=> (r_pos == '0 && r_etype == '0 && r_proto == '0))
        else $error("header state not cleared after frame");

    // Only a frame end loads a new result
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_adv && r_in_last))
        else $error("result appeared without a frame end");

endmodule

@@ dv/eiph_frame_checker.sv @@
// Frame summary scoreboard for the header parser: predicts each summary and compares it.
`timescale 1ns / 100ps
module eiph_frame_checker
    import eiph_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [BYTE_W-1:0]     i_s_tdata,       // data_byte[7:0]
    input  logic                  i_s_tlast,       // last_byte
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    // protocol[7:0], fragmented[8], dst_port[24:9], src_port[40:25],
    // tcp_flags[48:41], tcp_offset_byte[56:49], src_addr_high[120:57],
    // src_addr_low[184:121], frame_length[200:185], zero fill [207:201]
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    // accepted[0], family[2:1]
    input  logic [OUT_USER_W-1:0] i_m_tuser,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct {
        logic        accepted;
        logic [1:0]  family;
        logic [7:0]  protocol;
        logic        fragmented;
        logic [15:0] dst_port;
        logic [15:0] src_port;
        logic [7:0]  tcp_flags;
        logic [7:0]  tcp_offset;
        logic [63:0] src_high;
        logic [63:0] src_low;
        logic [15:0] frame_length;
    } t_frame_summary;

    // Predicted parser state for the frame in flight
    logic [15:0] pos_q;
    logic [15:0] etype_q;
    logic [3:0]  ihl_q;
    logic [15:0] frag_q;
    logic [7:0]  proto_q;
    logic [63:0] src_hi_q;
    logic [63:0] src_lo_q;
    logic [15:0] dport_q;
    logic [15:0] sport_q;
    logic [7:0]  tflags_q;
    logic [7:0]  toff_q;

    t_frame_summary summary_q[$];

    task automatic clear_state();
        pos_q    = '0;
        etype_q  = '0;
        ihl_q    = '0;
        frag_q   = '0;
        proto_q  = '0;
        src_hi_q = '0;
        src_lo_q = '0;
        dport_q  = '0;
        sport_q  = '0;
        tflags_q = '0;
        toff_q   = '0;
    endtask

    // Capture one of the first fourteen transport bytes
    task automatic take_transport(input int unsigned rel, input logic [7:0] b);
        case (rel)
            TP_SRC_HI:    sport_q[15:8] = b;
            TP_SRC_LO:    sport_q[7:0]  = b;
            TP_DST_HI:    dport_q[15:8] = b;
            TP_DST_LO:    dport_q[7:0]  = b;
            TCP_OFF_IDX:  toff_q        = b;
            TCP_FLAG_IDX: tflags_q      = b;
            default: ;
        endcase
    endtask

    // Fill in ports and TCP bytes when the transport header is complete
    function automatic t_frame_summary with_transport(input t_frame_summary s,
                                                      input int unsigned len,
                                                      input int unsigned t);
        t_frame_summary r;
        r = s;
        if (proto_q == PROTO_TCP && len >= t + TCP_HDR_LEN) begin
            r.dst_port   = dport_q;
            r.src_port   = sport_q;
            r.tcp_flags  = tflags_q;
            r.tcp_offset = toff_q;
        end else if (proto_q == PROTO_UDP && len >= t + UDP_HDR_LEN) begin
            r.dst_port = dport_q;
            r.src_port = sport_q;
        end
        return r;
    endfunction

    // Build the summary of a finished frame; rejected frames stay all zero
    function automatic t_frame_summary summarize(input int unsigned len);
        t_frame_summary s;
        int unsigned    t;
        s = '{default: '0};
        t = ETH_HDR_LEN + 4 * ihl_q;
        if (len < ETH_HDR_LEN) return s;
        if (etype_q == TYPE_V4) begin
            if (len < V4_MIN_LEN || ihl_q < MIN_IHL || len < t) return s;
            if ((frag_q & RESERVED_BIT) != 0) return s;
            s.accepted     = 1'b1;
            s.family       = FAM_V4;
            s.protocol     = proto_q;
            s.src_high     = {src_hi_q[63:32], 32'h0};
            s.frame_length = 16'(len);
            if ((frag_q & FRAG_MASK) != 0) s.fragmented = 1'b1;
            else s = with_transport(s, len, t);
        end else if (etype_q == TYPE_V6) begin
            if (len < V6_TRANSPORT) return s;
            s.accepted     = 1'b1;
            s.family       = FAM_V6;
            s.protocol     = proto_q;
            s.src_high     = src_hi_q;
            s.src_low      = src_lo_q;
            s.frame_length = 16'(len);
            if (proto_q == PROTO_FRAG6) s.fragmented = 1'b1;
            else s = with_transport(s, len, V6_TRANSPORT);
        end
        return s;
    endfunction

    // Advance the prediction by one accepted frame byte
    task automatic absorb_byte(input logic [7:0] b, input logic last);
        int unsigned pos;
        int unsigned len;
        int unsigned t;
        pos = pos_q;
        len = (pos_q == POS_MAX) ? POS_MAX : pos + 1;
        if (pos == ETYPE_POS_HI) etype_q[15:8] = b;
        else if (pos == ETYPE_POS_LO) etype_q[7:0] = b;

        if (etype_q == TYPE_V4 && pos >= ETH_HDR_LEN) begin
            if (pos == ETH_HDR_LEN) ihl_q = b[3:0];
            else if (pos == V4_FRAG_HI) frag_q[15:8] = b;
            else if (pos == V4_FRAG_LO) frag_q[7:0] = b;
            else if (pos == V4_PROTO_POS) proto_q = b;
            else if (pos >= V4_SRC_FIRST && pos <= V4_SRC_LAST)
                src_hi_q[8 * (7 - (pos - V4_SRC_FIRST)) +: 8] = b;
            // transport bytes only once a valid IHL is known
            if (pos > ETH_HDR_LEN && ihl_q >= MIN_IHL) begin
                t = ETH_HDR_LEN + 4 * ihl_q;
                if (pos >= t && pos < t + TRANSPORT_SPAN) take_transport(pos - t, b);
            end
        end else if (etype_q == TYPE_V6 && pos >= ETH_HDR_LEN) begin
            if (pos == V6_NH_POS) proto_q = b;
            else if (pos >= V6_SRC_FIRST && pos <= V6_SRC_MID)
                src_hi_q[8 * (7 - (pos - V6_SRC_FIRST)) +: 8] = b;
            else if (pos >= V6_SRC_LOW && pos <= V6_SRC_LAST)
                src_lo_q[8 * (7 - (pos - V6_SRC_LOW)) +: 8] = b;
            else if (pos >= V6_TRANSPORT && pos < V6_TRANSPORT + TRANSPORT_SPAN)
                take_transport(pos - V6_TRANSPORT, b);
        end

        if (!last) begin
            pos_q = 16'(len);
        end else begin
            summary_q.push_back(summarize(len));
            o_pending++;
            clear_state();
        end
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            if (o_fail_count < 10)
                $display("%0t: mismatch in %s: expected %h, got %h", $time, what, want, got);
            o_fail_count++;
        end
    endtask

    // Compare one accepted summary with the oldest prediction
    task automatic compare_summary();
        t_frame_summary want;
        if (summary_q.size() == 0) begin
            if (o_fail_count < 10)
                $display("%0t: summary item with no frame pending: tuser %h tdata %h",
                         $time, i_m_tuser, i_m_tdata);
            o_fail_count++;
        end else begin
            want = summary_q.pop_front();
            o_pending--;
            check_field("accepted",        want.accepted,     i_m_tuser[0]);
            check_field("family",          want.family,       i_m_tuser[2:1]);
            check_field("protocol",        want.protocol,     i_m_tdata[7:0]);
            check_field("fragmented",      want.fragmented,   i_m_tdata[8]);
            check_field("dst_port",        want.dst_port,     i_m_tdata[24:9]);
            check_field("src_port",        want.src_port,     i_m_tdata[40:25]);
            check_field("tcp_flags",       want.tcp_flags,    i_m_tdata[48:41]);
            check_field("tcp_offset_byte", want.tcp_offset,   i_m_tdata[56:49]);
            check_field("src_addr_high",   want.src_high,     i_m_tdata[120:57]);
            check_field("src_addr_low",    want.src_low,      i_m_tdata[184:121]);
            check_field("frame_length",    want.frame_length, i_m_tdata[200:185]);
            check_field("zero fill",       64'h0,             i_m_tdata[207:201]);
        end
    endtask

    // Watch both streams
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
            o_fail_count = 0;
            o_pending    = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) compare_summary();
            if (i_s_tvalid && i_s_tready) absorb_byte(i_s_tdata, i_s_tlast);
        end
    end

endmodule

@@ dv/tb_ethernet_ip_header_parser.sv @@
// Testbench top for the header parser: frame stimulus, stream idling and the verdict.
`timescale 1ns / 100ps
module tb_ethernet_ip_header_parser;
    import eiph_pkg::*;

    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 20;
    localparam int PHASE_BYTES  = 80;
    localparam int PHASE_FRAMES = 2;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata;   // data_byte[7:0]
    logic                  s_axis_tlast;   // last_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // protocol[7:0], fragmented[8], dst_port[24:9], src_port[40:25],
    // tcp_flags[48:41], tcp_offset_byte[56:49], src_addr_high[120:57],
    // src_addr_low[184:121], frame_length[200:185], zero fill [207:201]
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // accepted[0], family[2:1]
    logic [OUT_USER_W-1:0] m_axis_tuser;

    int         fail_count;
    int         pending;
    int         tx_idle_pct = 0;
    int         rx_stall_pct = 0;
    int         frames_sent = 0;
    int         bytes_sent = 0;
    bit         hold_done = 1'b0;
    logic [7:0] frame_q[$];

    ethernet_ip_header_parser u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    eiph_frame_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tlast    (s_axis_tlast),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stalls, plus one long hold-off early in the run
    initial begin : rx_side
        int hold_left;
        hold_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && frames_sent >= 3) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // End the run when neither stream moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILED: results differ");
        $finish;
    end

    // Offer one byte, with random idle cycles ahead of it, and wait for acceptance
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
        frames_sent++;
    endtask

    // Fill the frame with random bytes, or with a constant when pattern is set
    task automatic fill_bytes(input int len, input int pattern);
        frame_q.delete();
        repeat (len) frame_q.push_back(pattern < 0 ? 8'($urandom) : 8'(pattern));
    endtask

    task automatic poke(input int pos, input logic [7:0] v);
        if (pos < frame_q.size()) frame_q[pos] = v;
    endtask

    task automatic ipv4_frame(input int len, input logic [3:0] ihl, input logic [15:0] frag,
                              input logic [7:0] proto, input int pattern = -1);
        fill_bytes(len, pattern);
        poke(ETYPE_POS_HI, TYPE_V4[15:8]);
        poke(ETYPE_POS_LO, TYPE_V4[7:0]);
        poke(ETH_HDR_LEN, {4'($urandom), ihl});
        poke(V4_FRAG_HI, frag[15:8]);
        poke(V4_FRAG_LO, frag[7:0]);
        poke(V4_PROTO_POS, proto);
        send_frame();
    endtask

    task automatic ipv6_frame(input int len, input logic [7:0] nh);
        fill_bytes(len, -1);
        poke(ETYPE_POS_HI, TYPE_V6[15:8]);
        poke(ETYPE_POS_LO, TYPE_V6[7:0]);
        poke(V6_NH_POS, nh);
        send_frame();
    endtask

    task automatic typed_frame(input int len, input logic [15:0] etype);
        fill_bytes(len, -1);
        poke(ETYPE_POS_HI, etype[15:8]);
        poke(ETYPE_POS_LO, etype[7:0]);
        send_frame();
    endtask

    function automatic logic [7:0] pick_proto();
        int r;
        r = $urandom_range(9);
        if (r < 4) return PROTO_TCP;
        if (r < 8) return PROTO_UDP;
        if (r == 8) return PROTO_FRAG6;
        return 8'($urandom);
    endfunction

    // Bytes after the IP header: mostly a full transport header, sometimes cut short
    function automatic int pick_tail();
        if ($urandom_range(3) == 0) return $urandom_range(21);
        return $urandom_range(48, 20);
    endfunction

    task automatic random_frame();
        int          r;
        int          k;
        logic [3:0]  ihl;
        logic [15:0] frag;
        logic [15:0] etype;
        r = $urandom_range(99);
        ihl = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 6)) : MIN_IHL;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: frag = $urandom_range(1) ? 16'h4000 : 16'h0000;
            5, 6:          frag = 16'h2000 | 16'($urandom_range(16'h1FFF));
            7:             frag = 16'($urandom_range(16'h1FFF, 1));
            8:             frag = RESERVED_BIT | 16'($urandom);
            default:       frag = 16'($urandom);
        endcase
        if (r < 35) begin
            // IPv4 header of full length with a valid IHL, random flags and content
            ipv4_frame(ETH_HDR_LEN + 4 * ihl + pick_tail(), ihl, frag, pick_proto());
        end else if (r < 60) begin
            if ($urandom_range(9) == 0) ipv6_frame($urandom_range(53, 40), pick_proto());
            else ipv6_frame(V6_TRANSPORT + pick_tail(), pick_proto());
        end else if (r < 70) begin
            // broken IPv4: IHL too small or frame ends inside the IP header
            if ($urandom_range(1))
                ipv4_frame($urandom_range(80, 20), 4'($urandom_range(4)), frag, pick_proto());
            else
                ipv4_frame($urandom_range(ETH_HDR_LEN + 4 * ihl - 1, 14), ihl, frag,
                           pick_proto());
        end else if (r < 80) begin
            k = $urandom_range(15);
            case ($urandom_range(2))
                0:       etype = TYPE_V4 ^ (16'd1 << k);
                1:       etype = TYPE_V6 ^ (16'd1 << k);
                default: etype = 16'($urandom);
            endcase
            if (etype == TYPE_V4 || etype == TYPE_V6) etype ^= 16'd1;
            typed_frame($urandom_range(80, 14), etype);
        end else if (r < 90) begin
            ipv4_frame($urandom_range(33, 1), MIN_IHL, 16'h0000, PROTO_TCP);
        end else begin
            fill_bytes($urandom_range(90, 1), -1);
            send_frame();
        end
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct);
        int bytes_start;
        int frames_start;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        bytes_start  = bytes_sent;
        frames_start = frames_sent;
        while (bytes_sent - bytes_start < PHASE_BYTES || frames_sent - frames_start < PHASE_FRAMES)
            random_frame();
    endtask

    task automatic directed_frames();
        fill_bytes(1, -1);
        send_frame();
        ipv4_frame(13, MIN_IHL, 16'h0000, PROTO_TCP);
        ipv4_frame(14, MIN_IHL, 16'h0000, PROTO_TCP);
        ipv4_frame(33, MIN_IHL, 16'h0000, PROTO_TCP);
        ipv4_frame(34, MIN_IHL, 16'h0000, PROTO_TCP);
        ipv4_frame(53, MIN_IHL, 16'h0000, PROTO_TCP);
        ipv4_frame(54, MIN_IHL, 16'h4000, PROTO_TCP, 8'hFF);
        ipv4_frame(41, MIN_IHL, 16'h0000, PROTO_UDP);
        ipv4_frame(42, MIN_IHL, 16'h0000, PROTO_UDP, 8'h00);
        ipv4_frame(60, 4'd4, 16'h0000, PROTO_TCP);
        ipv4_frame(73, 4'd15, 16'h0000, PROTO_TCP);
        ipv4_frame(94, 4'd15, 16'h0000, PROTO_TCP);
        ipv4_frame(60, MIN_IHL, RESERVED_BIT, PROTO_TCP);
        ipv4_frame(60, MIN_IHL, 16'h2000, PROTO_TCP);
        ipv4_frame(60, MIN_IHL, 16'h0001, PROTO_UDP);
        ipv4_frame(60, MIN_IHL, 16'h0000, 8'd1);
        ipv6_frame(53, PROTO_TCP);
        ipv6_frame(54, PROTO_TCP);
        ipv6_frame(74, PROTO_TCP);
        ipv6_frame(61, PROTO_UDP);
        ipv6_frame(62, PROTO_UDP);
        ipv6_frame(80, PROTO_FRAG6);
        ipv6_frame(80, 8'd58);
        typed_frame(60, 16'h0801);
        typed_frame(60, 16'h86DC);
        typed_frame(60, 16'hFFFF);
    endtask

    initial begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        i_rst_n       <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_frames();
        run_phase(0, 0);
        run_phase(77, 0);
        run_phase(0, 77);
        run_phase(38, 38);
        s_axis_tvalid <= 1'b0;

        // drain outstanding summaries, then watch for stray items
        while (pending != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
